>>> rtl/core/bmesh_pkg.sv
// ----------------------------------------------------------------------------
// bmesh_pkg
// Types and constants shared by the box mesh triangle index generator.
// ----------------------------------------------------------------------------
package bmesh_pkg;

  localparam int MAX_VERTS = 256;
  localparam int VERT_W    = 9;    // vertex count register width
  localparam int CELL_W    = 8;    // cell coordinate width
  localparam int IDX_W     = 19;   // vertex index width, indices wrap mod 2^19
  localparam int PROD_W    = CELL_W + VERT_W;

  // face pair codes
  localparam logic [1:0] FACE_Z = 2'd0;
  localparam logic [1:0] FACE_Y = 2'd1;
  localparam logic [1:0] FACE_X = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_VERTS_X = 2'd0;
  localparam logic [1:0] REG_VERTS_Y = 2'd1;
  localparam logic [1:0] REG_VERTS_Z = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CELL_W-1:0] cell_u;
    logic [CELL_W-1:0] cell_v;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic             bad_cell;
    logic             last_tri;
  } triangle_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } corners_t;

endpackage

>>> rtl/core/box_mesh_triangle_index_generator.sv
// ----------------------------------------------------------------------------
// box_mesh_triangle_index_generator
// Each item names a face pair (Z, Y or X) and one grid cell; the block returns
// the vertex indices of four triangles, two on the minus face and then two on
// the plus face, with border cells stitched to vertices of neighboring faces.
// A cell outside the configured grid, or an unused face code, returns a single
// result with bad_cell set and all corners zero. Vertex counts per axis are
// written through the cfg port (values clamp to 2..MAX_VERTS); the user must
// write them only while the block is idle, which the block does not enforce.
// Items pass an input register, a multiply stage and a triangle buffer. The
// buffer drains one triangle per cycle while triangle_stall is low and takes
// the next item as its last triangle is taken, so a stream of good cells is
// paced by the result channel; a bad cell returns only one triangle.
// ----------------------------------------------------------------------------
module box_mesh_triangle_index_generator
  import bmesh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              triangle_valid,
  input  logic              triangle_stall,
  output triangle_t         triangle,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [VERT_W-1:0] cfg_data
);

  function automatic logic [VERT_W-1:0] clamp_verts(input logic [VERT_W-1:0] val);
    logic [VERT_W-1:0] res;
    res = val;
    if (val < VERT_W'(2)) res = VERT_W'(2);
    if (val > VERT_W'(MAX_VERTS)) res = VERT_W'(MAX_VERTS);
    return res;
  endfunction

  // configuration
  logic [VERT_W-1:0] verts_x, verts_y, verts_z;
  logic [IDX_W-1:0]  base_r;    // 2*vx*vy: first Y-row vertex
  logic [IDX_W-1:0]  base2_r;   // 2*vx*(vy+vz-2): first X-row vertex
  logic [IDX_W-1:0]  zplus_r;   // 2*vy*(vx-1): far Z-plane column offset

  logic [VERT_W:0] yz_sum;
  assign yz_sum = {1'b0, verts_y} + {1'b0, verts_z} - (VERT_W+1)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      verts_x <= VERT_W'(2);
      verts_y <= VERT_W'(2);
      verts_z <= VERT_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTS_X: verts_x <= clamp_verts(cfg_data);
        REG_VERTS_Y: verts_y <= clamp_verts(cfg_data);
        REG_VERTS_Z: verts_z <= clamp_verts(cfg_data);
        default: ;
      endcase
    end
    base_r  <= IDX_W'({(2*VERT_W+1)'(verts_x) * (2*VERT_W+1)'(verts_y), 1'b0});
    base2_r <= IDX_W'({(2*VERT_W+1)'(verts_x) * (2*VERT_W+1)'(yz_sum), 1'b0});
    zplus_r <= IDX_W'({(2*VERT_W+1)'(verts_y) *
                       (2*VERT_W+1)'(verts_x - VERT_W'(1)), 1'b0});
  end

  // pipeline control
  logic s1_valid, s2_valid, s3_valid;
  logic s2_load, s3_load, s3_done, out_xfer;
  logic [1:0] cnt;
  logic       s3_bad;
  corners_t   tris [4];

  assign out_xfer = s3_valid && !triangle_stall;
  assign s3_done  = out_xfer && triangle.last_tri;
  assign s3_load  = s2_valid && (!s3_valid || s3_done);
  assign s2_load  = s1_valid && (!s2_valid || s3_load);
  assign item_stall = s1_valid && !s2_load;

  // stage 1: input register
  item_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) s1 <= item;
  end

  // stage 1 -> 2: range checks, border flags, products
  logic [VERT_W-1:0] vxm2, vym2, vzm2, u9, v9;
  logic [CELL_W-1:0] mul_a;
  logic [VERT_W-1:0] mul_b;
  logic              bad_next;

  assign vxm2 = verts_x - VERT_W'(2);
  assign vym2 = verts_y - VERT_W'(2);
  assign vzm2 = verts_z - VERT_W'(2);
  assign u9   = {1'b0, s1.cell_u};
  assign v9   = {1'b0, s1.cell_v};
  assign mul_a = (s1.req_type == FACE_Y) ? s1.cell_v : s1.cell_u;
  assign mul_b = (s1.req_type == FACE_X) ? vym2 : verts_y;

  always_comb begin
    unique case (s1.req_type)
      FACE_Z:  bad_next = (u9 > vxm2) || (v9 > vym2);
      FACE_Y:  bad_next = (u9 > vzm2) || (v9 > vxm2);
      FACE_X:  bad_next = (u9 > vzm2) || (v9 > vym2);
      default: bad_next = 1'b1;
    endcase
  end

  logic [1:0]        s2_face;
  logic [CELL_W-1:0] s2_v;
  logic              s2_bad, s2_zf, s2_zl, s2_yf, s2_yl;
  logic [PROD_W-1:0] s2_m1, s2_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || s3_load) begin
      s2_valid <= s1_valid;
    end
    if (s2_load) begin
      s2_face <= s1.req_type;
      s2_v    <= s1.cell_v;
      s2_bad  <= bad_next;
      s2_zf   <= (s1.cell_u == '0);
      s2_zl   <= (u9 == vzm2);
      s2_yf   <= (s1.cell_v == '0);
      s2_yl   <= (v9 == vym2);
      s2_m1   <= PROD_W'(s1.cell_u) * PROD_W'(verts_x);
      s2_m2   <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // stage 2 -> 3: corner indices
  logic [IDX_W-1:0] vx2, vy2, vv2, mm1, mm2;
  logic [IDX_W-1:0] g_tl, g_tr, g_bl, g_br, rt, rb, xo;
  logic [IDX_W-1:0] tlm, trm, blm, brm, tlp, trp, blp, brp;
  corners_t         tris_next [4];

  assign vx2 = IDX_W'({verts_x, 1'b0});
  assign vy2 = IDX_W'({verts_y, 1'b0});
  assign vv2 = IDX_W'({s2_v, 1'b0});
  assign mm1 = IDX_W'({s2_m1, 1'b0});
  assign mm2 = IDX_W'({s2_m2, 1'b0});
  assign rt  = base_r + mm1;
  assign rb  = rt - vx2;
  assign xo  = vx2 - IDX_W'(2);

  always_comb begin
    g_tl = '0; g_tr = '0; g_bl = '0; g_br = '0;
    tlm = '0; trm = '0; blm = '0; brm = '0;
    tlp = '0; trp = '0; blp = '0; brp = '0;
    unique case (s2_face)
      FACE_Z: begin
        tlm = vv2 + mm2;
        trm = tlm + IDX_W'(2);
        blm = tlm + vy2;
        brm = blm + IDX_W'(2);
        tlp = tlm + IDX_W'(1);
        trp = trm + IDX_W'(1);
        blp = blm + IDX_W'(1);
        brp = brm + IDX_W'(1);
      end
      FACE_Y: begin
        g_tl = base_r + vv2 + mm1;
        g_tr = g_tl + IDX_W'(2);
        g_bl = g_tl - vx2;
        g_br = g_bl + IDX_W'(2);
        // bottom row joins the minus Z plane, top row the plus Z plane
        tlm = s2_zl ? mm2 + IDX_W'(1)       : g_tl;
        trm = s2_zl ? mm2 + vy2 + IDX_W'(1) : g_tr;
        blm = s2_zf ? mm2                   : g_bl;
        brm = s2_zf ? mm2 + vy2             : g_br;
        tlp = s2_zl ? mm2 + vy2 - IDX_W'(1)       : g_tl + IDX_W'(1);
        trp = s2_zl ? mm2 + vy2 + vy2 - IDX_W'(1) : g_tr + IDX_W'(1);
        blp = s2_zf ? mm2 + vy2 - IDX_W'(2)       : g_bl + IDX_W'(1);
        brp = s2_zf ? mm2 + vy2 + vy2 - IDX_W'(2) : g_br + IDX_W'(1);
      end
      FACE_X: begin
        g_tl = base2_r + vv2 + mm2 - IDX_W'(2);
        g_tr = g_tl + IDX_W'(2);
        g_bl = g_tl - vy2 + IDX_W'(4);
        g_br = g_bl + IDX_W'(2);
        // Z planes win over the Y rows at the corners
        tlm = s2_zl ? vv2 + IDX_W'(1) : (s2_yf ? rt : g_tl);
        trm = s2_zl ? vv2 + IDX_W'(3) : (s2_yl ? rt + IDX_W'(1) : g_tr);
        blm = s2_zf ? vv2             : (s2_yf ? rb : g_bl);
        brm = s2_zf ? vv2 + IDX_W'(2) : (s2_yl ? rb + IDX_W'(1) : g_br);
        tlp = s2_zl ? vv2 + zplus_r + IDX_W'(1)
                    : (s2_yf ? rt + xo : g_tl + IDX_W'(1));
        trp = s2_zl ? vv2 + zplus_r + IDX_W'(3)
                    : (s2_yl ? rt + xo + IDX_W'(1) : g_tr + IDX_W'(1));
        blp = s2_zf ? vv2 + zplus_r
                    : (s2_yf ? rb + xo : g_bl + IDX_W'(1));
        brp = s2_zf ? vv2 + zplus_r + IDX_W'(2)
                    : (s2_yl ? rb + xo + IDX_W'(1) : g_br + IDX_W'(1));
      end
      default: ;
    endcase

    // Y faces wind the other way
    if (s2_bad) begin
      for (int i = 0; i < 4; i++) tris_next[i] = '0;
    end else if (s2_face == FACE_Y) begin
      tris_next[0] = '{a: tlm, b: blm, c: trm};
      tris_next[1] = '{a: trm, b: blm, c: brm};
      tris_next[2] = '{a: trp, b: blp, c: tlp};
      tris_next[3] = '{a: brp, b: blp, c: trp};
    end else begin
      tris_next[0] = '{a: trm, b: blm, c: tlm};
      tris_next[1] = '{a: brm, b: blm, c: trm};
      tris_next[2] = '{a: tlp, b: blp, c: trp};
      tris_next[3] = '{a: trp, b: blp, c: brp};
    end
  end

  // stage 3: triangle buffer, drained one transfer at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      cnt      <= '0;
    end else if (s3_load) begin
      s3_valid <= 1'b1;
      cnt      <= '0;
    end else if (s3_done) begin
      s3_valid <= 1'b0;
      cnt      <= '0;
    end else if (out_xfer) begin
      cnt <= cnt + 2'd1;
    end
    if (s3_load) begin
      s3_bad <= s2_bad;
      for (int i = 0; i < 4; i++) tris[i] <= tris_next[i];
    end
  end

  assign triangle_valid    = s3_valid;
  assign triangle.corner_a = tris[cnt].a;
  assign triangle.corner_b = tris[cnt].b;
  assign triangle.corner_c = tris[cnt].c;
  assign triangle.bad_cell = s3_bad;
  assign triangle.last_tri = s3_bad || (cnt == 2'd3);

  // checks
  assert property (@(posedge clk) disable iff (rst)
    triangle_valid && triangle.bad_cell |->
      triangle.last_tri && triangle.corner_a == '0 &&
      triangle.corner_b == '0 && triangle.corner_c == '0)
    else $error("bad cell result not a single zero triangle");

  assert property (@(posedge clk) disable iff (rst)
    s3_valid && !s3_bad |-> (cnt != 2'd0) || !triangle.last_tri)
    else $error("good cell ended after its first triangle");

  assert property (@(posedge clk) disable iff (rst)
    out_xfer && !triangle.last_tri |=> s3_valid && cnt == $past(cnt) + 2'd1)
    else $error("triangle counter skipped or buffer dropped");

  assert property (@(posedge clk) disable iff (rst)
    s3_valid && triangle_stall |=> s3_valid && $stable(cnt))
    else $error("triangle buffer moved while stalled");

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s3_load |=> s2_valid)
    else $error("stage 2 item lost");

endmodule
